// File: rtl/pfl_pkg.sv
// Shared types and constants for the page frame lookup unit.
`timescale 1ns / 1ps

package pfl_pkg;

    localparam int ADDR_W    = 24;
    localparam int PID_W     = 8;
    localparam int PSIZE_W   = 17;
    localparam int OFFSET_W  = 16;
    localparam int STAMP_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int FIDX_W    = 4;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = 17'd256;
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_MAX   = 17'h10000;
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_MIN   = 17'd1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACE = 2'd2;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [ADDR_W-1:0] address;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   frame_index;
        logic [ADDR_W-1:0]   page_number;
        logic [OFFSET_W-1:0] page_offset;
    } out_t;

    // Classified access handed from the front end to the table walker.
    typedef struct packed {
        logic [PID_W-1:0]    proc_id;
        logic [ADDR_W-1:0]   page_number;
        logic [OFFSET_W-1:0] page_offset;
    } job_t;

endpackage

// File: rtl/pfl_fifo.sv
// Two-entry queue used between the front end, the table walker and the result port.
`timescale 1ns / 1ps

module pfl_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/pfl_front.sv
// Front end: takes an access word and splits the address into page and offset.
`timescale 1ns / 1ps

module pfl_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  pfl_pkg::in_t                         in_word,
    input  logic [pfl_pkg::PSIZE_W-1:0]          page_size,
    output logic                                 job_push,
    input  logic                                 job_full,
    output pfl_pkg::job_t                        job_word
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } state_t;

    state_t                              state_reg;
    logic [4:0]                          step_reg;
    logic [pfl_pkg::PID_W-1:0]           pid_reg;
    logic [pfl_pkg::PSIZE_W-1:0]         div_reg;
    logic [pfl_pkg::ADDR_W-1:0]          quo_reg;
    logic [pfl_pkg::OFFSET_W-1:0]        rem_reg;
    logic [pfl_pkg::PSIZE_W-1:0]         div_next;
    logic [pfl_pkg::PSIZE_W-1:0]         trial;
    logic [pfl_pkg::PSIZE_W-1:0]         diff;
    logic                                q_bit;
    logic [pfl_pkg::ADDR_W-1:0]          quo_next;
    logic [pfl_pkg::OFFSET_W-1:0]        rem_next;
    logic                                accept;

    assign full     = (state_reg != F_IDLE);
    assign accept   = push && !full;
    assign job_push = (state_reg == F_PUSH);
    assign job_word = '{proc_id: pid_reg, page_number: quo_reg, page_offset: rem_reg};

    // A zero page size acts as one, anything past the maximum as the maximum.
    always_comb
    begin
        if (page_size == '0)
            div_next = pfl_pkg::PAGE_SIZE_MIN;
        else if (page_size > pfl_pkg::PAGE_SIZE_MAX)
            div_next = pfl_pkg::PAGE_SIZE_MAX;
        else
            div_next = page_size;
    end

    // One restoring division step per cycle; the remainder stays below the divisor.
    always_comb
    begin
        trial = {rem_reg, quo_reg[pfl_pkg::ADDR_W-1]};
        diff  = trial - div_reg;
        q_bit = (trial >= div_reg);
        if (q_bit)
            rem_next = diff[pfl_pkg::OFFSET_W-1:0];
        else
            rem_next = trial[pfl_pkg::OFFSET_W-1:0];
        quo_next = {quo_reg[pfl_pkg::ADDR_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 5'd0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_DIV;
                        step_reg  <= 5'd0;
                    end
                end
                F_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(pfl_pkg::ADDR_W - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!job_full)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pid_reg <= in_word.proc_id;
            div_reg <= div_next;
            quo_reg <= in_word.address;
            rem_reg <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// File: rtl/pfl_back.sv
// Table walker: scans the frame table, picks the frame and updates it.
`timescale 1ns / 1ps

module pfl_back #(
    parameter int FRAMES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_empty,
    output logic          job_pop,
    input  pfl_pkg::job_t job_word,
    output logic          res_push,
    input  logic          res_full,
    output pfl_pkg::out_t res_word
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    typedef struct packed {
        logic [pfl_pkg::ADDR_W-1:0]  page;
        logic [pfl_pkg::PID_W-1:0]   owner;
        logic [pfl_pkg::STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_WRITE
    } state_t;

    entry_t                       slot_mem [FRAMES];
    entry_t                       rd_data_reg;
    logic [FRAMES-1:0]            valid_reg;
    state_t                       state_reg;
    pfl_pkg::job_t                job_reg;
    logic [pfl_pkg::STAMP_W-1:0]  clock_reg;
    logic [CNT_W-1:0]             scan_cnt_reg;
    logic                         cmp_vld_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic                         cmp_valid_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    logic                         free_reg;
    logic [IDX_W-1:0]             free_idx_reg;
    logic [IDX_W-1:0]             min_idx_reg;
    logic [pfl_pkg::STAMP_W-1:0]  min_stamp_reg;

    logic [IDX_W-1:0]             rd_addr;
    logic                         issue;
    logic                         last_cmp;
    logic [IDX_W-1:0]             pick_idx;
    logic [pfl_pkg::STATUS_W-1:0] pick_status;
    logic [IDX_W+3:0]             pick_ext;
    logic                         write_now;
    entry_t                       wr_entry;

    assign rd_addr   = scan_cnt_reg[IDX_W-1:0];
    assign issue     = (state_reg == B_SCAN) && (scan_cnt_reg != CNT_W'(FRAMES));
    assign last_cmp  = cmp_vld_reg && (cmp_idx_reg == IDX_W'(FRAMES - 1));
    assign job_pop   = (state_reg == B_IDLE) && !job_empty;
    assign write_now = (state_reg == B_WRITE) && !res_full;
    assign res_push  = (state_reg == B_WRITE);

    // A hit wins, then the first free frame, then the oldest stamp.
    always_comb
    begin
        priority if (hit_reg)
        begin
            pick_idx    = hit_idx_reg;
            pick_status = pfl_pkg::ST_HIT;
        end
        else if (free_reg)
        begin
            pick_idx    = free_idx_reg;
            pick_status = pfl_pkg::ST_FREE;
        end
        else
        begin
            pick_idx    = min_idx_reg;
            pick_status = pfl_pkg::ST_REPLACE;
        end
    end

    assign pick_ext = {4'b0000, pick_idx};
    assign wr_entry = '{page: job_reg.page_number, owner: job_reg.proc_id, stamp: clock_reg};
    assign res_word = '{status:      pick_status,
                        frame_index: pick_ext[3:0],
                        page_number: job_reg.page_number,
                        page_offset: job_reg.page_offset};

    always_ff @(posedge clk)
    begin
        if (write_now)
            slot_mem[pick_idx] <= wr_entry;
        if (issue)
            rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            valid_reg    <= '0;
            clock_reg    <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        state_reg    <= B_SCAN;
                        scan_cnt_reg <= '0;
                        cmp_vld_reg  <= 1'b0;
                        if (clock_reg != '1)
                            clock_reg <= clock_reg + 32'd1;
                    end
                end
                B_SCAN:
                begin
                    cmp_vld_reg <= issue;
                    if (issue)
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if (last_cmp)
                        state_reg <= B_WRITE;
                end
                B_WRITE:
                begin
                    if (!res_full)
                    begin
                        state_reg           <= B_IDLE;
                        valid_reg[pick_idx] <= 1'b1;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    // Scan bookkeeping: memory data for a frame arrives in the cycle after its read.
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg  <= job_word;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (issue)
        begin
            cmp_idx_reg   <= rd_addr;
            cmp_valid_reg <= valid_reg[rd_addr];
        end
        if ((state_reg == B_SCAN) && cmp_vld_reg)
        begin
            if (!hit_reg && cmp_valid_reg
                && (rd_data_reg.page == job_reg.page_number)
                && (rd_data_reg.owner == job_reg.proc_id))
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!free_reg && !cmp_valid_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (rd_data_reg.stamp < min_stamp_reg))
            begin
                min_idx_reg   <= cmp_idx_reg;
                min_stamp_reg <= rd_data_reg.stamp;
            end
        end
    end

endmodule

// File: rtl/page_frame_lookup_lru_unit.sv
// The serial divider front end feeds the table walker; it takes a new access once its
// last job is queued. The rate is set by the serial divider (one quotient bit per cycle)
// and by the one-frame-per-cycle read port of the frame table.
// Reset clears every frame's valid bit at once, zeroes the access counter and sets the
// page size to 256; there is no clearing pass and the unit takes words right after reset.
`timescale 1ns / 1ps

module page_frame_lookup_lru_unit #(
    parameter int FRAMES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  pfl_pkg::in_t                in_word,
    output logic                        empty,
    input  logic                        pop,
    output pfl_pkg::out_t               out_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pfl_pkg::PSIZE_W-1:0] cfg_data
);

    logic [pfl_pkg::PSIZE_W-1:0] page_size_reg;
    logic                        job_push;
    logic                        job_full;
    logic                        job_pop;
    logic                        job_empty;
    pfl_pkg::job_t               job_in;
    pfl_pkg::job_t               job_out;
    logic                        res_push;
    logic                        res_full;
    pfl_pkg::out_t               res_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            page_size_reg <= pfl_pkg::PAGE_SIZE_RESET;
        else if (cfg_valid && cfg_ready)
            page_size_reg <= cfg_data;
    end

    pfl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .page_size (page_size_reg),
        .job_push  (job_push),
        .job_full  (job_full),
        .job_word  (job_in)
    );

    pfl_fifo #(
        .W ($bits(pfl_pkg::job_t))
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .full  (job_full),
        .wdata (job_in),
        .pop   (job_pop),
        .empty (job_empty),
        .rdata (job_out)
    );

    pfl_back #(
        .FRAMES (FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job_word  (job_out),
        .res_push  (res_push),
        .res_full  (res_full),
        .res_word  (res_word)
    );

    pfl_fifo #(
        .W ($bits(pfl_pkg::out_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_word),
        .pop   (pop),
        .empty (empty),
        .rdata (out_word)
    );

endmodule
